@@ design/pdfc_pkg.sv @@
// Shared types and constants for the PWM duty and frequency capture block.
package pdfc_pkg;

   localparam int unsigned CAP_W     = 16;
   localparam int unsigned OVF_W     = 16;
   localparam int unsigned TICK_W    = 32;
   localparam int unsigned CLK_W     = 27;
   localparam int unsigned DUTY_W    = 7;
   localparam int unsigned FREQ_W    = 16;
   localparam int unsigned DIVD_W    = 39;
   localparam int unsigned DIVS_W    = 32;
   localparam int unsigned STEP_W    = 6;

   localparam logic [CLK_W-1:0]  CLK_RESET  = 27'd8000000;
   localparam logic [6:0]        PERCENT    = 7'd100;
   localparam logic [STEP_W-1:0] DUTY_STEPS = 6'd39;
   localparam logic [STEP_W-1:0] FREQ_STEPS = 6'd27;
   localparam logic [OVF_W-1:0]  OVF_MAX    = 16'hFFFF;
   localparam logic [FREQ_W-1:0] FREQ_MAX   = 16'hFFFF;
   localparam logic [TICK_W-1:0] TICK_MAX   = 32'hFFFF_FFFF;

   localparam logic EVT_OVERFLOW = 1'b0;
   localparam logic EVT_CAPTURE  = 1'b1;

   typedef struct packed {
      logic             req_type;
      logic [CAP_W-1:0] capture_value;
   } req_item_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty_percent;
      logic [FREQ_W-1:0] frequency_hz;
      logic [TICK_W-1:0] high_ticks;
      logic [TICK_W-1:0] period_ticks;
      logic              bad_period;
   } rsp_item_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
      logic [STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVD_W-1:0] quotient;
   } div_rsp_type;

endpackage

@@ design/pdfc_divider.sv @@
// Restoring serial divider that produces one quotient bit per cycle.
module pdfc_divider (
   input  logic                  clock,
   input  logic                  reset,
   input  pdfc_pkg::div_req_type div_req,
   output pdfc_pkg::div_rsp_type div_rsp
);

   logic [pdfc_pkg::DIVS_W-1:0] rem_ff,   rem_in;
   logic [pdfc_pkg::DIVD_W-1:0] num_ff,   num_in;
   logic [pdfc_pkg::DIVD_W-1:0] quo_ff,   quo_in;
   logic [pdfc_pkg::DIVS_W-1:0] dvs_ff,   dvs_in;
   logic [pdfc_pkg::STEP_W-1:0] count_ff, count_in;
   logic                        busy_ff,  busy_in;
   logic                        done_ff,  done_in;

   logic [pdfc_pkg::DIVS_W:0]   trial;
   logic [pdfc_pkg::DIVS_W:0]   diff;
   logic                        fits;

   always_comb begin
      trial    = {rem_ff, num_ff[pdfc_pkg::DIVD_W-1]};
      diff     = trial - {1'b0, dvs_ff};
      fits     = (trial >= {1'b0, dvs_ff});
      rem_in   = rem_ff;
      num_in   = num_ff;
      quo_in   = quo_ff;
      dvs_in   = dvs_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (div_req.start) begin
         rem_in   = '0;
         num_in   = div_req.dividend;
         quo_in   = '0;
         dvs_in   = div_req.divisor;
         count_in = div_req.steps;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[pdfc_pkg::DIVS_W-1:0] : trial[pdfc_pkg::DIVS_W-1:0];
         num_in   = {num_ff[pdfc_pkg::DIVD_W-2:0], 1'b0};
         quo_in   = {quo_ff[pdfc_pkg::DIVD_W-2:0], fits};
         count_in = count_ff - 1'b1;
         if (count_ff == pdfc_pkg::STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

@@ design/pwm_duty_frequency_capture.sv @@
// Top level of the PWM duty-cycle and frequency capture block.
//
// The req channel carries timer events: an overflow event (req_type 0) or an
// edge capture with the latched timer count. The rsp channel carries one
// result after every third capture: high time, period, duty in percent,
// frequency and a flag for a zero period. The csr port writes the timer
// clock rate in ticks per second at any cycle that csr_wr_en is high.
// An overflow event leaves the block idle and ready for the next event. A
// first or second capture passes through ST_CALC before the next transfer.
// A third capture forms interval and period in ST_CALC and ST_SUM, then
// one serial divider computes the duty (39 steps) and then the frequency
// (27 steps), one quotient bit per cycle; a zero period skips both. That
// divider sets the rate, and no new event is taken until ST_IDLE again.
// The result sits in an output register, so a new event is taken while the
// result waits; a later third capture holds in ST_DONE until the receiver
// has taken the earlier result. Synchronous reset returns the block to
// awaiting a first edge with the clock rate at 8000000.
module pwm_duty_frequency_capture #(
   parameter int unsigned TIMER_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  pdfc_pkg::req_item_type        req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output pdfc_pkg::rsp_item_type        rsp_data,
   input  logic                          csr_wr_en,
   input  logic [pdfc_pkg::CLK_W-1:0]    csr_wr_data
);

   localparam int unsigned UP_W   = pdfc_pkg::OVF_W + TIMER_BITS + 1;
   localparam int unsigned WIDE_W = (UP_W > pdfc_pkg::TICK_W + 1) ? UP_W
                                                                   : pdfc_pkg::TICK_W + 1;
   localparam logic [pdfc_pkg::CAP_W-1:0] CAP_MASK =
      (TIMER_BITS >= pdfc_pkg::CAP_W) ? {pdfc_pkg::CAP_W{1'b1}}
                                      : pdfc_pkg::CAP_W'((64'd1 << TIMER_BITS) - 64'd1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_CALC, ST_SUM, ST_DUTY_GO, ST_DUTY_WAIT, ST_FREQ_GO, ST_FREQ_WAIT, ST_DONE
   } state_type;

   state_type                     state_ff,  state_in;
   logic [1:0]                    phase_ff,  phase_in;
   logic [pdfc_pkg::OVF_W-1:0]    ovf_ff,    ovf_in;
   logic [pdfc_pkg::CAP_W-1:0]    last_ff,   last_in;
   logic [pdfc_pkg::CAP_W-1:0]    cap_ff,    cap_in;
   logic [pdfc_pkg::TICK_W-1:0]   high_ff,   high_in;
   logic [pdfc_pkg::TICK_W-1:0]   low_ff,    low_in;
   logic [pdfc_pkg::TICK_W-1:0]   period_ff, period_in;
   logic [pdfc_pkg::DUTY_W-1:0]   duty_ff,   duty_in;
   logic [pdfc_pkg::FREQ_W-1:0]   freq_ff,   freq_in;
   logic [pdfc_pkg::CLK_W-1:0]    clk_hz_ff, clk_hz_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   pdfc_pkg::rsp_item_type        rsp_data_ff,  rsp_data_in;

   logic [WIDE_W-1:0]             up_w;
   logic [WIDE_W-1:0]             prev_w;
   logic [WIDE_W-1:0]             diff_w;
   logic [pdfc_pkg::TICK_W-1:0]   interval;
   logic [pdfc_pkg::TICK_W:0]     period_sum;
   logic [pdfc_pkg::FREQ_W-1:0]   freq_sat;

   pdfc_pkg::div_req_type         div_req;
   pdfc_pkg::div_rsp_type         div_rsp;

   pdfc_divider u_divider (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      up_w   = (WIDE_W'(ovf_ff) << TIMER_BITS) + WIDE_W'(cap_ff);
      prev_w = WIDE_W'(last_ff);
      diff_w = up_w - prev_w;
      if (up_w < prev_w) begin
         interval = '0;
      end else if (|diff_w[WIDE_W-1:pdfc_pkg::TICK_W]) begin
         interval = pdfc_pkg::TICK_MAX;
      end else begin
         interval = diff_w[pdfc_pkg::TICK_W-1:0];
      end
      period_sum = {1'b0, high_ff} + {1'b0, low_ff};
      freq_sat   = (|div_rsp.quotient[pdfc_pkg::CLK_W-1:pdfc_pkg::FREQ_W])
                   ? pdfc_pkg::FREQ_MAX : div_rsp.quotient[pdfc_pkg::FREQ_W-1:0];
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      cap_in       = cap_ff;
      high_in      = high_ff;
      low_in       = low_ff;
      period_in    = period_ff;
      duty_in      = duty_ff;
      freq_in      = freq_ff;
      clk_hz_in    = csr_wr_en ? csr_wr_data : clk_hz_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_req      = '0;
      req_ready    = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.req_type == pdfc_pkg::EVT_OVERFLOW) begin
                  if (ovf_ff != pdfc_pkg::OVF_MAX) begin
                     ovf_in = ovf_ff + 1'b1;
                  end
               end else begin
                  cap_in   = req_data.capture_value & CAP_MASK;
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            last_in  = cap_ff;
            ovf_in   = '0;
            state_in = ST_IDLE;
            if (phase_ff == 2'd1) begin
               high_in  = interval;
               phase_in = 2'd2;
            end else if (phase_ff == 2'd2) begin
               low_in   = interval;
               phase_in = 2'd0;
               state_in = ST_SUM;
            end else begin
               phase_in = 2'd1;
            end
         end
         ST_SUM: begin
            period_in = period_sum[pdfc_pkg::TICK_W] ? pdfc_pkg::TICK_MAX
                                                      : period_sum[pdfc_pkg::TICK_W-1:0];
            duty_in   = '0;
            freq_in   = '0;
            state_in  = ST_DUTY_GO;
         end
         ST_DUTY_GO: begin
            if (period_ff == '0) begin
               state_in = ST_DONE;
            end else begin
               div_req.start    = 1'b1;
               div_req.dividend = pdfc_pkg::DIVD_W'(high_ff) *
                                  pdfc_pkg::DIVD_W'(pdfc_pkg::PERCENT);
               div_req.divisor  = period_ff;
               div_req.steps    = pdfc_pkg::DUTY_STEPS;
               state_in         = ST_DUTY_WAIT;
            end
         end
         ST_DUTY_WAIT: begin
            if (div_rsp.done) begin
               duty_in  = div_rsp.quotient[pdfc_pkg::DUTY_W-1:0];
               state_in = ST_FREQ_GO;
            end
         end
         ST_FREQ_GO: begin
            div_req.start    = 1'b1;
            div_req.dividend = {clk_hz_ff, {(pdfc_pkg::DIVD_W - pdfc_pkg::CLK_W){1'b0}}};
            div_req.divisor  = period_ff;
            div_req.steps    = pdfc_pkg::FREQ_STEPS;
            state_in         = ST_FREQ_WAIT;
         end
         ST_FREQ_WAIT: begin
            if (div_rsp.done) begin
               freq_in  = freq_sat;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.duty_percent = duty_ff;
               rsp_data_in.frequency_hz = freq_ff;
               rsp_data_in.high_ticks   = high_ff;
               rsp_data_in.period_ticks = period_ff;
               rsp_data_in.bad_period   = (period_ff == '0);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         ovf_ff       <= '0;
         last_ff      <= '0;
         high_ff      <= '0;
         clk_hz_ff    <= pdfc_pkg::CLK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         high_ff      <= high_in;
         clk_hz_ff    <= clk_hz_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cap_ff      <= cap_in;
      low_ff      <= low_in;
      period_ff   <= period_in;
      duty_ff     <= duty_in;
      freq_ff     <= freq_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("A result appeared without the sequencer finishing a cycle.");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_DUTY_WAIT || state_ff == ST_FREQ_WAIT))
      else $error("The divider finished while no division was awaited.");

   a_bad_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bad_period) |->
      (rsp_data_ff.duty_percent == '0 && rsp_data_ff.frequency_hz == '0))
      else $error("A zero period result carries a nonzero duty or frequency.");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.duty_percent <= pdfc_pkg::PERCENT))
      else $error("The duty exceeds one hundred percent.");

endmodule

@@ bench/pdfc_checker.sv @@
// Checker that predicts and compares capture results for the PWM duty and frequency block.
`timescale 1ns / 100ps

module pdfc_checker
   import pdfc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_item_type         req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_item_type         rsp_data,
   input  logic                 csr_wr_en,
   input  logic [CLK_W-1:0]     csr_wr_data,
   output int                   fail_count,
   output int                   waiting_n,
   output int                   result_count
);

   typedef enum logic [1:0] {
      AWAIT_FIRST,
      AWAIT_SECOND,
      AWAIT_THIRD
   } edge_state_e;

   logic [CLK_W-1:0]  tick_rate;
   edge_state_e       capture_state;
   logic [OVF_W-1:0]  ovf_seen;
   logic [TICK_W-1:0] prev_edge;
   logic [TICK_W-1:0] high_span;
   rsp_item_type      measured_q[$];
   int                errors = 0;
   int                checked = 0;

   assign fail_count   = errors;
   assign result_count = checked;

   function automatic logic [TICK_W-1:0] edge_span(input logic [CAP_W-1:0] cap);
      logic [63:0] upper;
      logic [63:0] diff;
      upper = (64'(ovf_seen) << CAP_W) + 64'(cap);
      if (upper < 64'(prev_edge)) return '0;
      diff = upper - 64'(prev_edge);
      if (diff > 64'(TICK_MAX)) return TICK_MAX;
      return diff[TICK_W-1:0];
   endfunction

   task automatic take_event(input req_item_type it);
      logic [TICK_W-1:0] low_span;
      logic [63:0]       period;
      logic [63:0]       duty;
      logic [63:0]       freq;
      rsp_item_type      r;
      if (it.req_type == EVT_OVERFLOW) begin
         if (ovf_seen != OVF_MAX) ovf_seen = ovf_seen + 1'b1;
      end else begin
         case (capture_state)
            AWAIT_SECOND: begin
               high_span     = edge_span(it.capture_value);
               capture_state = AWAIT_THIRD;
            end
            AWAIT_THIRD: begin
               low_span = edge_span(it.capture_value);
               period   = 64'(high_span) + 64'(low_span);
               if (period > 64'(TICK_MAX)) period = 64'(TICK_MAX);
               r              = '0;
               r.high_ticks   = high_span;
               r.period_ticks = period[TICK_W-1:0];
               if (period == 64'd0) begin
                  r.bad_period = 1'b1;
               end else begin
                  duty = (64'(high_span) * 64'(PERCENT)) / period;
                  freq = 64'(tick_rate) / period;
                  if (freq > 64'(FREQ_MAX)) freq = 64'(FREQ_MAX);
                  r.duty_percent = duty[DUTY_W-1:0];
                  r.frequency_hz = freq[FREQ_W-1:0];
               end
               measured_q.push_back(r);
               capture_state = AWAIT_FIRST;
            end
            default: begin
               capture_state = AWAIT_SECOND;
            end
         endcase
         prev_edge = TICK_W'(it.capture_value);
         ovf_seen  = '0;
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         tick_rate     = CLK_RESET;
         capture_state = AWAIT_FIRST;
         ovf_seen      = '0;
         prev_edge     = '0;
         high_span     = '0;
         measured_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (measured_q.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, got %p",
                        $time, rsp_data);
               errors++;
            end else begin
               want = measured_q.pop_front();
               checked++;
               check_field("duty_percent", 64'(want.duty_percent), 64'(rsp_data.duty_percent));
               check_field("frequency_hz", 64'(want.frequency_hz), 64'(rsp_data.frequency_hz));
               check_field("high_ticks", 64'(want.high_ticks), 64'(rsp_data.high_ticks));
               check_field("period_ticks", 64'(want.period_ticks), 64'(rsp_data.period_ticks));
               check_field("bad_period", 64'(want.bad_period), 64'(rsp_data.bad_period));
            end
         end
         if (req_valid && req_ready) take_event(req_data);
         if (csr_wr_en) tick_rate = csr_wr_data;
      end
      waiting_n <= measured_q.size();
   end

endmodule

@@ bench/tb_pwm_duty_frequency_capture.sv @@
// Testbench top that drives capture events and clock-rate writes and reports the verdict.
`timescale 1ns / 100ps

module tb_pwm_duty_frequency_capture;
   import pdfc_pkg::*;

   localparam int HOLD_CYCLES = 600;
   localparam int IDLE_GAP    = 100;
   localparam int PHASE_ITEMS = 100;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_item_type     req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_item_type     rsp_data;
   logic             csr_wr_en;
   logic [CLK_W-1:0] csr_wr_data;

   logic             calm;
   logic             rx_hold_req;
   logic             hold_done;
   logic [CAP_W-1:0] last_cap;
   int               fail_count;
   int               waiting_n;
   int               result_count;
   int               event_count;
   int               rate_settings;

   pwm_duty_frequency_capture uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   pdfc_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .fail_count   (fail_count),
      .waiting_n    (waiting_n),
      .result_count (result_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_event(input logic kind, input logic [CAP_W-1:0] val);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{req_type: kind, capture_value: val};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      event_count++;
      if (kind == EVT_CAPTURE) last_cap = val;
   endtask

   task automatic send_overflows(input int n);
      repeat (n) send_event(EVT_OVERFLOW, CAP_W'($urandom));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (waiting_n != 0) @(posedge clock);
      repeat (IDLE_GAP) @(posedge clock);
   endtask

   task automatic set_rate(input logic [CLK_W-1:0] value);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      rate_settings++;
   endtask

   function automatic logic [CAP_W-1:0] pick_capture();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      if (r < 5) return last_cap + CAP_W'($urandom_range(0, 50));
      if (r == 5) return last_cap - CAP_W'($urandom_range(1, 50));
      return CAP_W'($urandom);
   endfunction

   function automatic int pick_overflows();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 2);
      return $urandom_range(3, 6);
   endfunction

   task automatic run_random(input int n_items);
      int target;
      target = event_count + n_items;
      while (event_count < target) begin
         if ($urandom_range(0, 9) == 0) begin
            send_event(1'($urandom), CAP_W'($urandom));
         end else begin
            repeat (3) begin
               send_overflows(pick_overflows());
               send_event(EVT_CAPTURE, pick_capture());
            end
         end
      end
   endtask

   initial begin
      logic [CLK_W-1:0] rates [4];
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      calm          = 1'b0;
      rx_hold_req   = 1'b0;
      last_cap      = '0;
      event_count   = 0;
      rate_settings = 1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Overflows ahead of the first capture must be discarded.
      send_overflows(2);
      send_event(EVT_CAPTURE, 16'd100);
      send_event(EVT_CAPTURE, 16'd300);
      send_event(EVT_CAPTURE, 16'd1100);
      // Zero period.
      send_event(EVT_CAPTURE, 16'd5);
      send_event(EVT_CAPTURE, 16'd5);
      send_event(EVT_CAPTURE, 16'd5);
      // A capture below the previous one with no overflow gives a zero interval.
      send_event(EVT_CAPTURE, 16'd1000);
      send_event(EVT_CAPTURE, 16'd10);
      send_event(EVT_CAPTURE, 16'd20);
      // Intervals that span timer overflows.
      send_event(EVT_CAPTURE, 16'hFFFF);
      send_overflows(1);
      send_event(EVT_CAPTURE, 16'd0);
      send_overflows(2);
      send_event(EVT_CAPTURE, 16'hFFFF);
      // Very short period saturates the frequency.
      send_event(EVT_CAPTURE, 16'd0);
      send_event(EVT_CAPTURE, 16'd1);
      send_event(EVT_CAPTURE, 16'd2);
      wait_idle();

      // Long runs of overflows give intervals of many timer wraps.
      calm = 1'b1;
      send_event(EVT_CAPTURE, 16'd0);
      send_overflows(40);
      send_event(EVT_CAPTURE, 16'hFFFF);
      send_overflows(40);
      send_event(EVT_CAPTURE, 16'hFFFF);
      calm = 1'b0;

      rates[0] = 27'd100000000;
      rates[1] = 27'd1;
      rates[2] = CLK_W'($urandom_range(2, 99999999));
      rates[3] = CLK_RESET;
      for (int i = 0; i < 4; i++) begin
         wait_idle();
         set_rate(rates[i]);
         if (i == 1) rx_hold_req <= 1'b1;
         calm = (i == 2);
         run_random(PHASE_ITEMS);
      end

      wait_idle();
      $display("Run covered %0d timer events and %0d checked measurements over %0d rates,",
               event_count, result_count, rate_settings);
      $display("with long overflow spans, zero periods and a long stall on the result side.");
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // The result side stalls at random and, once on request, holds off long enough to
   // back the block up onto its input.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      hold_done = 1'b0;
      forever begin
         if (rx_hold_req && !hold_done) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            stall = pick_gap();
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

endmodule

@@ pwm_duty_frequency_capture.f @@
design/pdfc_pkg.sv
design/pdfc_divider.sv
design/pwm_duty_frequency_capture.sv
bench/pdfc_checker.sv
bench/tb_pwm_duty_frequency_capture.sv
